@@ sv/wbps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

    localparam int NUM_PATTERN_BYTES = 16;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_SEL_W = 3;

    localparam logic [REG_SEL_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_CARE_MASK    = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_PATTERN_LEN  = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_BASE_ADDRESS = 3'd4;

    typedef struct packed {
        logic rd_ok;
        logic byte_ok;
    } cell_stat_t;

endpackage

`default_nettype wire

@@ sv/wbps_byte_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface wbps_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       readable;
    logic       region_end;

    modport source (output valid, output data_byte, output readable, output region_end,
                    input ready);
    modport sink (input valid, input data_byte, input readable, input region_end,
                  output ready);
endinterface

`default_nettype wire

@@ sv/wbps_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface wbps_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

@@ sv/wildcard_byte_pattern_scanner_core.sv @@
// Wildcard byte pattern scanner.
// The byte_stream channel carries one byte of a memory region per request, with a
// readable flag and a region_end flag on the last byte. The result channel carries
// at most one request per region: found with the address of the first matching
// window, or found = 0 with address 0 when the region ends without a match.
// Pattern, care mask, length and base address are to be written over the APB port
// while the scanner is idle; the block itself does not enforce this. pready is
// always high and reads return the register value. A row of MAX_PATTERN cells
// holds the byte window; each cell compares its byte with the pattern byte at its
// position, and the row's results are combined in the same cycle, so one byte can be
// taken every cycle. A result is registered and shown in the cycle after its byte.
// While a result waits and the receiver stalls, byte_stream.ready is low; otherwise
// a byte is taken in every cycle, also in the cycle in which a result is taken.
// Bytes after a match are taken and dropped until the end of the region.
// Reset clears the window, the region counters and the registers (length to one).
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_scanner_core #(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    wbps_byte_if.sink                              byte_stream,
    wbps_result_if.source                          result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [wbps_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [wbps_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    localparam int LEN_W = (MAX_PATTERN < 2) ? 1 : $clog2(MAX_PATTERN + 1);

    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [15:0] care_mask_reg;
    logic [4:0]  pattern_len_reg;
    logic [63:0] base_address_reg;

    logic [wbps_pkg::REG_SEL_W-1:0] reg_sel;
    logic                           cfg_write;

    logic [63:0]      bytes_seen_reg;
    logic [63:0]      bytes_seen_next;
    logic [LEN_W-1:0] skip_count_reg;
    logic [LEN_W-1:0] skip_count_next;
    logic             match_done_reg;
    logic             match_done_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             found_reg;
    logic             found_next;
    logic [63:0]      addr_reg;
    logic [63:0]      addr_next;

    logic [LEN_W-1:0] used_len;
    logic [63:0]      seen_inc;
    logic             in_acc;
    logic             process;
    logic             clear;
    logic             window_full;
    logic             all_rd;
    logic             all_byte;
    logic             hit;
    logic             emit;

    logic [7:0]                pat_bytes [wbps_pkg::NUM_PATTERN_BYTES];
    logic [7:0]                win_byte [MAX_PATTERN];
    logic                      win_rd [MAX_PATTERN];
    wbps_pkg::cell_stat_t      stat [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]    rd_vec;
    logic [MAX_PATTERN-1:0]    byte_vec;

    // Configuration port.
    assign reg_sel = paddr[wbps_pkg::APB_ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg <= 64'd0;
            pattern_high_reg <= 64'd0;
            care_mask_reg <= 16'd0;
            pattern_len_reg <= 5'd1;
            base_address_reg <= 64'd0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                wbps_pkg::REG_PATTERN_LOW:  pattern_low_reg <= pwdata;
                wbps_pkg::REG_PATTERN_HIGH: pattern_high_reg <= pwdata;
                wbps_pkg::REG_CARE_MASK:    care_mask_reg <= pwdata[15:0];
                wbps_pkg::REG_PATTERN_LEN:  pattern_len_reg <= pwdata[4:0];
                wbps_pkg::REG_BASE_ADDRESS: base_address_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            wbps_pkg::REG_PATTERN_LOW:  prdata = pattern_low_reg;
            wbps_pkg::REG_PATTERN_HIGH: prdata = pattern_high_reg;
            wbps_pkg::REG_CARE_MASK:    prdata = {48'd0, care_mask_reg};
            wbps_pkg::REG_PATTERN_LEN:  prdata = {59'd0, pattern_len_reg};
            wbps_pkg::REG_BASE_ADDRESS: prdata = base_address_reg;
            default:                    prdata = 64'd0;
        endcase
    end

    // A length of zero counts as one, and lengths above the window are clipped.
    always_comb
    begin
        if (pattern_len_reg == 5'd0)
        begin
            used_len = LEN_W'(1);
        end
        else if (32'(pattern_len_reg) > 32'(MAX_PATTERN))
        begin
            used_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            used_len = LEN_W'(pattern_len_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < wbps_pkg::NUM_PATTERN_BYTES; i++)
        begin
            if (i < 8)
            begin
                pat_bytes[i] = pattern_low_reg[8*i +: 8];
            end
            else
            begin
                pat_bytes[i] = pattern_high_reg[8*(i-8) +: 8];
            end
        end
    end

    assign in_acc = byte_stream.valid && byte_stream.ready;
    assign process = in_acc && !match_done_reg;
    assign clear = in_acc && byte_stream.region_end;

    // Cell g holds the byte that is g places older than the newest one.
    for (genvar g = 0; g < MAX_PATTERN; g++)
    begin : g_cell
        logic [LEN_W-1:0] pos;
        logic             active;
        logic [7:0]       want;
        logic             must_match;
        logic [7:0]       byte_in;
        logic             rd_in;

        always_comb
        begin
            pos = used_len - LEN_W'(1) - LEN_W'(g);
            active = 32'(used_len) > 32'(g);
            want = 8'd0;
            must_match = 1'b0;
            if (32'(pos) < 32'(wbps_pkg::NUM_PATTERN_BYTES))
            begin
                want = pat_bytes[4'(pos)];
                must_match = care_mask_reg[4'(pos)];
            end
        end

        if (g == 0)
        begin : g_head
            assign byte_in = byte_stream.data_byte;
            assign rd_in = byte_stream.readable;
        end
        else
        begin : g_link
            assign byte_in = win_byte[g-1];
            assign rd_in = win_rd[g-1];
        end

        wbps_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (process),
            .clear      (clear),
            .active     (active),
            .byte_in    (byte_in),
            .rd_in      (rd_in),
            .want       (want),
            .must_match (must_match),
            .byte_q     (win_byte[g]),
            .rd_q       (win_rd[g]),
            .stat       (stat[g])
        );

        assign rd_vec[g] = stat[g].rd_ok;
        assign byte_vec[g] = stat[g].byte_ok;
    end

    assign all_rd = &rd_vec;
    assign all_byte = &byte_vec;

    assign seen_inc = (bytes_seen_reg == '1) ? bytes_seen_reg : bytes_seen_reg + 64'd1;
    assign window_full = seen_inc >= 64'(used_len);

    always_comb
    begin
        hit = 1'b0;
        bytes_seen_next = bytes_seen_reg;
        skip_count_next = skip_count_reg;
        match_done_next = match_done_reg;
        if (process)
        begin
            bytes_seen_next = seen_inc;
            if (window_full)
            begin
                if (skip_count_reg != '0)
                begin
                    skip_count_next = skip_count_reg - LEN_W'(1);
                end
                else if (!all_rd)
                begin
                    skip_count_next = used_len - LEN_W'(1);
                end
                else
                begin
                    hit = all_byte;
                end
            end
            if (hit)
            begin
                match_done_next = 1'b1;
            end
        end
        if (clear)
        begin
            bytes_seen_next = 64'd0;
            skip_count_next = '0;
            match_done_next = 1'b0;
        end
    end

    assign emit = process && (hit || byte_stream.region_end);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next = found_reg;
        addr_next = addr_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            found_next = hit;
            addr_next = hit ? (base_address_reg + seen_inc - 64'(used_len)) : 64'd0;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= 64'd0;
            skip_count_reg <= '0;
            match_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bytes_seen_reg <= bytes_seen_next;
            skip_count_reg <= skip_count_next;
            match_done_reg <= match_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        addr_reg <= addr_next;
    end

    assign byte_stream.ready = !out_valid_reg || result.ready;
    assign result.valid = out_valid_reg;
    assign result.found = found_reg;
    assign result.match_address = addr_reg;

    // A not-found result always carries a zero address.
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (addr_reg == 64'd0))
        else $error("not-found result with a nonzero address");

    // Bytes after a match produce no result until the region ends.
    a_quiet_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && match_done_reg && !byte_stream.region_end) |=> !out_valid_reg)
        else $error("result produced after a match in the same region");

    // The last byte of a region leaves the region state cleared.
    a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (bytes_seen_reg == 64'd0 && skip_count_reg == '0 && !match_done_reg))
        else $error("region state not cleared at region end");

    // A held result blocks new bytes.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !byte_stream.ready)
        else $error("byte taken while a result is stalled");

endmodule

`default_nettype wire

@@ sv/wbps_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                shift_en,
    input  wire logic                clear,
    input  wire logic                active,
    input  wire logic [7:0]          byte_in,
    input  wire logic                rd_in,
    input  wire logic [7:0]          want,
    input  wire logic                must_match,
    output logic [7:0]               byte_q,
    output logic                     rd_q,
    output wbps_pkg::cell_stat_t     stat
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       rd_reg;
    logic       rd_next;

    always_comb
    begin
        byte_next = byte_reg;
        rd_next = rd_reg;
        if (clear)
        begin
            byte_next = 8'd0;
            rd_next = 1'b0;
        end
        else if (shift_en)
        begin
            byte_next = byte_in;
            rd_next = rd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
            rd_reg <= 1'b0;
        end
        else
        begin
            byte_reg <= byte_next;
            rd_reg <= rd_next;
        end
    end

    // The check looks at the window as it stands after this request shifts in.
    assign stat.rd_ok = !active || rd_in;
    assign stat.byte_ok = !active || !must_match || (byte_in == want);

    assign byte_q = byte_reg;
    assign rd_q = rd_reg;

endmodule

`default_nettype wire
